>>> src/stq_pkg.sv
// Shared types and constants for the sorted timer queue scheduler.
`default_nettype none
package stq_pkg;
    localparam int SLOT_COUNT = 16;
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        KIND_ARM    = 2'd0,
        KIND_MODIFY = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_POLL   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REPLY_ACK      = 2'd0,
        REPLY_DISPATCH = 2'd1,
        REPLY_DONE     = 2'd2
    } reply_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WAIT  = 2'd1,
        ST_READY = 2'd2
    } slot_state_t;

    localparam logic [0:0] REG_RESOLUTION = 1'b0;
    localparam logic [0:0] REG_POLLS      = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_STEP,
        CMD_UNLINK_P,
        CMD_UNLINK_R,
        CMD_SCAN_P,
        CMD_INSERT_P,
        CMD_PUSH_READY,
        CMD_CHECK_FRONT,
        CMD_POLL_START,
        CMD_POP_READY,
        CMD_TICK
    } cmd_t;

    typedef struct packed {
        logic            div_done;
        logic            delay_zero;
        logic            slot_valid;
        slot_state_t     slot_state;
        logic            scan_stop;
        logic            fire;
        logic            do_check;
        logic            front_expired;
        logic            ready_empty;
        logic            unlink_done;
        logic [SW-1:0]   pop_slot;
        logic [3:0]      cur_slot;
    } status_t;
endpackage
`default_nettype wire

>>> src/stq_datapath.sv
// Datapath of the scheduler: slot tables, lists, divider and tick state.
`default_nettype none
module stq_datapath
    import stq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [3:0]  in_slot,
    input  wire logic [31:0] in_timeout,
    input  var  cmd_t        cmd,
    output status_t          status
);
    logic [15:0] res_reg;
    logic [15:0] ppc_reg;
    logic [1:0]  st_reg [SLOT_COUNT];
    logic [31:0] start_mem [SLOT_COUNT];
    logic [31:0] dur_mem [SLOT_COUNT];
    logic [SW-1:0] pend_reg [SLOT_COUNT];
    logic [SW-1:0] rdy_reg [SLOT_COUNT];
    logic [CW-1:0] pcnt_reg;
    logic [CW-1:0] rcnt_reg;
    logic [31:0] tick_reg;
    logic [31:0] lchk_reg;
    logic [15:0] pollc_reg;
    logic [3:0]  slot_reg;
    logic        svalid_reg;
    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] upos_reg;
    logic        fire_reg;
    logic        chk_reg;
    logic [SW-1:0] sidx;
    logic [16:0] res_eff;
    logic [16:0] rem_sh;
    logic [SW-1:0] scan_s;
    logic [31:0] scan_el;
    logic [31:0] scan_rm;
    logic [SW-1:0] fr_s;
    logic [31:0] fr_el;
    logic        p_hit;
    logic        r_hit;
    logic [SW-1:0] pop_s;

    assign sidx = slot_reg[SW-1:0];
    assign res_eff = (res_reg == 16'd0) ? 17'd1 : {1'b0, res_reg};
    assign rem_sh = {rem_reg[15:0], quo_reg[31]};

    assign scan_s = pend_reg[pos_reg[SW-1:0]];
    assign scan_el = (tick_reg >= start_mem[scan_s]) ? (tick_reg - start_mem[scan_s])
                   : ((32'hffffffff - start_mem[scan_s]) + tick_reg);
    assign scan_rm = (scan_el >= dur_mem[scan_s]) ? 32'd0 : (dur_mem[scan_s] - scan_el);
    assign fr_s = pend_reg[0];
    assign fr_el = (tick_reg >= start_mem[fr_s]) ? (tick_reg - start_mem[fr_s])
                 : ((32'hffffffff - start_mem[fr_s]) + tick_reg);
    assign p_hit = (pend_reg[upos_reg[SW-1:0]] == sidx);
    assign r_hit = (rdy_reg[upos_reg[SW-1:0]] == sidx);
    assign pop_s = rdy_reg[rcnt_reg[SW-1:0] - SW'(1)];

    always_comb
    begin
        status.div_done      = (dcnt_reg == 6'd32);
        status.delay_zero    = (quo_reg == 32'd0);
        status.slot_valid    = svalid_reg;
        status.slot_state    = slot_state_t'(st_reg[sidx]);
        status.scan_stop     = (pos_reg == pcnt_reg) || (scan_rm > quo_reg);
        status.fire          = fire_reg;
        status.do_check      = chk_reg;
        status.front_expired = (pcnt_reg != '0) && (fr_el >= dur_mem[fr_s]);
        status.ready_empty   = (rcnt_reg == '0);
        status.unlink_done   = (cmd == CMD_UNLINK_P) ? ((upos_reg >= pcnt_reg) || p_hit)
                                                     : ((upos_reg >= rcnt_reg) || r_hit);
        status.pop_slot      = pop_s;
        status.cur_slot      = slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg   <= 16'd10;
            ppc_reg   <= 16'd100;
            pcnt_reg  <= '0;
            rcnt_reg  <= '0;
            tick_reg  <= '0;
            lchk_reg  <= '0;
            pollc_reg <= '0;
            dcnt_reg  <= '0;
            fire_reg  <= 1'b0;
            chk_reg   <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                st_reg[i] <= ST_IDLE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_RESOLUTION)
                begin
                    res_reg <= cfg_data;
                end
                else
                begin
                    ppc_reg <= cfg_data;
                end
            end
            unique case (cmd)
                CMD_LOAD:
                begin
                    slot_reg   <= in_slot;
                    svalid_reg <= ({28'd0, in_slot} < 32'(SLOT_COUNT));
                    quo_reg    <= in_timeout;
                    rem_reg    <= '0;
                    dcnt_reg   <= '0;
                    pos_reg    <= '0;
                    upos_reg   <= '0;
                end
                CMD_DIV_STEP:
                begin
                    if (rem_sh >= res_eff)
                    begin
                        rem_reg <= rem_sh - res_eff;
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                end
                CMD_UNLINK_P:
                begin
                    if (upos_reg < pcnt_reg)
                    begin
                        if (p_hit)
                        begin
                            for (int j = 0; j < SLOT_COUNT - 1; j++)
                            begin
                                if (CW'(j) >= upos_reg)
                                begin
                                    pend_reg[j] <= pend_reg[j + 1];
                                end
                            end
                            pcnt_reg <= pcnt_reg - CW'(1);
                            st_reg[sidx] <= ST_IDLE;
                        end
                        else
                        begin
                            upos_reg <= upos_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        st_reg[sidx] <= ST_IDLE;
                    end
                end
                CMD_UNLINK_R:
                begin
                    if (upos_reg < rcnt_reg)
                    begin
                        if (r_hit)
                        begin
                            for (int j = 0; j < SLOT_COUNT - 1; j++)
                            begin
                                if (CW'(j) >= upos_reg)
                                begin
                                    rdy_reg[j] <= rdy_reg[j + 1];
                                end
                            end
                            rcnt_reg <= rcnt_reg - CW'(1);
                            st_reg[sidx] <= ST_IDLE;
                        end
                        else
                        begin
                            upos_reg <= upos_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        st_reg[sidx] <= ST_IDLE;
                    end
                end
                CMD_SCAN_P:
                begin
                    pos_reg <= pos_reg + CW'(1);
                end
                CMD_INSERT_P:
                begin
                    st_reg[sidx]    <= ST_WAIT;
                    dur_mem[sidx]   <= quo_reg;
                    start_mem[sidx] <= tick_reg;
                    if (pcnt_reg < CW'(SLOT_COUNT))
                    begin
                        for (int j = 1; j < SLOT_COUNT; j++)
                        begin
                            if (CW'(j) > pos_reg && CW'(j) <= pcnt_reg)
                            begin
                                pend_reg[j] <= pend_reg[j - 1];
                            end
                        end
                        pend_reg[pos_reg[SW-1:0]] <= sidx;
                        pcnt_reg <= pcnt_reg + CW'(1);
                    end
                end
                CMD_PUSH_READY:
                begin
                    if (rcnt_reg < CW'(SLOT_COUNT))
                    begin
                        rdy_reg[rcnt_reg[SW-1:0]] <= sidx;
                        rcnt_reg <= rcnt_reg + CW'(1);
                    end
                    st_reg[sidx] <= ST_READY;
                end
                CMD_POLL_START:
                begin
                    fire_reg <= (pollc_reg > ppc_reg);
                    chk_reg  <= (pollc_reg > ppc_reg) && (tick_reg != lchk_reg);
                    if (pollc_reg > ppc_reg)
                    begin
                        pollc_reg <= '0;
                        if (tick_reg != lchk_reg)
                        begin
                            lchk_reg <= tick_reg;
                        end
                    end
                    else
                    begin
                        pollc_reg <= pollc_reg + 16'd1;
                    end
                end
                CMD_CHECK_FRONT:
                begin
                    for (int j = 0; j < SLOT_COUNT - 1; j++)
                    begin
                        pend_reg[j] <= pend_reg[j + 1];
                    end
                    pcnt_reg <= pcnt_reg - CW'(1);
                    if (rcnt_reg < CW'(SLOT_COUNT))
                    begin
                        rdy_reg[rcnt_reg[SW-1:0]] <= fr_s;
                        rcnt_reg <= rcnt_reg + CW'(1);
                    end
                    st_reg[fr_s] <= ST_READY;
                end
                CMD_POP_READY:
                begin
                    rcnt_reg <= rcnt_reg - CW'(1);
                    st_reg[pop_s] <= ST_IDLE;
                end
                CMD_TICK:
                begin
                    tick_reg <= tick_reg + 32'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pcnt_reg <= CW'(SLOT_COUNT))
        else $error("pending count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) rcnt_reg <= CW'(SLOT_COUNT))
        else $error("ready count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_POP_READY |-> rcnt_reg != '0)
        else $error("pop from empty ready stack");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_TICK |=> tick_reg == $past(tick_reg) + 32'd1)
        else $error("tick did not advance");
endmodule
`default_nettype wire

>>> src/stq_ctrl.sv
// Controller state machine that sequences each request and drives results.
`default_nettype none
module stq_ctrl
    import stq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  in_kind,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output cmd_t             cmd,
    input  var  status_t     status
);
    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_DECIDE, S_UNLINK, S_ARM, S_SCAN, S_INSERT,
        S_PUSH, S_POLL, S_CHECK, S_POP, S_DONE, S_OUT
    } state_t;

    state_t      state_reg;
    logic [1:0]  kind_reg;
    logic        rearm_reg;
    logic        unr_reg;
    logic        post_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;
    logic [3:0]  sslot;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign sslot    = 4'(status.pop_slot);

    always_comb
    begin
        cmd = CMD_NONE;
        unique case (state_reg)
            S_IDLE:   cmd = (s_tvalid) ? CMD_LOAD : CMD_NONE;
            S_DIV:    cmd = status.div_done ? CMD_NONE : CMD_DIV_STEP;
            S_UNLINK: cmd = unr_reg ? CMD_UNLINK_R : CMD_UNLINK_P;
            S_SCAN:   cmd = status.scan_stop ? CMD_NONE : CMD_SCAN_P;
            S_INSERT: cmd = CMD_INSERT_P;
            S_PUSH:   cmd = CMD_PUSH_READY;
            S_POLL:   cmd = CMD_POLL_START;
            S_CHECK:  cmd = (status.do_check && status.front_expired)
                            ? CMD_CHECK_FRONT : CMD_NONE;
            S_POP:    cmd = (!m_tvalid_reg || m_tready) && !status.ready_empty
                            ? CMD_POP_READY : CMD_NONE;
            S_DONE:   cmd = (!m_tvalid_reg || m_tready) ? CMD_TICK : CMD_NONE;
            default:  cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            kind_reg     <= KIND_ARM;
            rearm_reg    <= 1'b0;
            unr_reg      <= 1'b0;
            post_reg     <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg  <= in_kind;
                        rearm_reg <= 1'b0;
                        state_reg <= (kind_t'(in_kind) == KIND_POLL) ? S_POLL : S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    unr_reg  <= 1'b0;
                    post_reg <= 1'b0;
                    state_reg <= S_OUT;
                    if (status.slot_valid)
                    begin
                        unique case (kind_t'(kind_reg))
                            KIND_ARM:
                            begin
                                if (status.slot_state == ST_WAIT)
                                begin
                                    post_reg  <= 1'b1;
                                    state_reg <= S_UNLINK;
                                end
                                else if (status.slot_state == ST_IDLE)
                                begin
                                    state_reg <= S_ARM;
                                end
                            end
                            KIND_MODIFY:
                            begin
                                if (status.slot_state == ST_WAIT)
                                begin
                                    post_reg  <= 1'b1;
                                    rearm_reg <= 1'b1;
                                    state_reg <= S_UNLINK;
                                end
                            end
                            default:
                            begin
                                unr_reg   <= (status.slot_state == ST_READY);
                                state_reg <= S_UNLINK;
                            end
                        endcase
                    end
                end
                S_UNLINK:
                begin
                    if (status.unlink_done)
                    begin
                        state_reg <= post_reg ? S_ARM : S_OUT;
                    end
                end
                S_ARM:
                begin
                    state_reg <= status.delay_zero ? S_PUSH : S_SCAN;
                end
                S_SCAN:
                begin
                    if (status.scan_stop)
                    begin
                        state_reg <= S_INSERT;
                    end
                end
                S_INSERT, S_PUSH:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, rearm_reg, status.cur_slot, REPLY_ACK};
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_POLL:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!status.do_check || !status.front_expired)
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        if (status.ready_empty)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= {2'b00, sslot, REPLY_DISPATCH};
                            m_tlast_reg  <= 1'b0;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, 4'd0, REPLY_DONE};
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted during work");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_POP_READY) |-> (state_reg == S_POP))
        else $error("pop outside dispatch");
endmodule
`default_nettype wire

>>> src/sorted_timer_queue_scheduler_core.sv
// Top level of the sorted timer queue scheduler.
// Arm and modify run a 32-step restoring divider, then, as needed, an unlink
// walk and a scan of the pending list. Delete runs the divider and an unlink
// walk; a poll may move expired slots to the ready stack and then dispatches
// each ready slot, results held by the output register. One request at a time.
// Reset is asynchronous and active low; all slots become idle at once.
`default_nettype none
module sorted_timer_queue_scheduler_core
    import stq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // kind[1:0], slot[5:2], timeout_ms[37:6], zeros
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [7:0]       m_tdata,   // reply[1:0], served_slot[5:2], rearmed[6], zero
    output logic             m_tlast
);
    cmd_t    cmd;
    status_t status;

    stq_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_slot(s_tdata[5:2]), .in_timeout(s_tdata[37:6]),
        .cmd(cmd), .status(status)
    );

    stq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .in_kind(s_tdata[1:0]),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cmd(cmd), .status(status)
    );
endmodule
`default_nettype wire
